FILE: hw/rtl/wwkm_pkg.sv
// Shared types, constants and character helpers for the whole-word keyword matcher.
`timescale 1ns / 1ps
`default_nettype none

package wwkm_pkg;

    // Default keyword window and column limit
    localparam int unsigned      KEY_BYTES_DEF  = 16;
    localparam longint unsigned  COLUMN_MAX_DEF = 64'd65535;

    // Result queue depth: room for two results from one request plus slack
    localparam int unsigned      Q_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KEY_LOW    = 3'd0,
        CFG_KEY_HIGH   = 3'd1,
        CFG_KEY_LEN    = 3'd2,
        CFG_EXACT_CASE = 3'd3,
        CFG_WHOLE_WORD = 3'd4
    } t_cfg_reg;

    // One reported match
    typedef struct packed {
        logic [31:0] line_number;
        logic [15:0] match_column;
        logic [31:0] total_matches;
        logic        last_result;
    } t_result;

    // Letters, digits and '-' belong to a word
    function automatic logic is_word(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h2D};
    endfunction

    // Fold upper case letters to lower case unless exact case is asked for
    function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
        if (!exact && (c inside {[8'h41:8'h5A]})) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Add one, stopping at all ones
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/whole_word_keyword_matcher.sv
// Top level of the whole-word keyword matcher: input register, match logic, result queue.
//
// Usage: text enters one byte per request on the input channel (i_valid / o_stall) with
// byte-present, end-of-line and start-of-file markers. Each request can produce zero,
// one or two match reports on the output channel (o_valid / i_stall); the last report
// of a request carries o_last_result.
// Configuration (keyword bytes, length, case mode, whole-word mode) is written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write it only while no request is
// in flight, as the block itself does not enforce this.
// An accepted request waits in the input register until two queue entries are free, its
// reports go into the result queue, and the first is presented from the queue head.
// Throughput: one request per cycle while at least two result queue entries are free.
// The KEY_BYTES-wide parallel compare against the window of recent bytes is combinational;
// reports leave through the output port one per cycle while the receiver does not stall.
// A four-entry result queue sits between the match logic and the output; the input
// register stalls only when fewer than two queue entries are free.
// Reset (synchronous, active low) restarts the line count at one, clears the match total,
// the byte window and the queue, restores the default configuration, holds o_stall high.
// When the receiver stalls, o_valid and the report payload hold until taken.
`timescale 1ns / 1ps
`default_nettype none

module whole_word_keyword_matcher #(
    parameter int unsigned     KEY_BYTES  = wwkm_pkg::KEY_BYTES_DEF,
    parameter longint unsigned COLUMN_MAX = wwkm_pkg::COLUMN_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // text input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_line,
    input  wire logic        i_start_of_file,
    // match report channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_line_number,
    output logic [15:0]      o_match_column,
    output logic [31:0]      o_total_matches,
    output logic             o_last_result
);

    localparam int LW  = $clog2(KEY_BYTES + 1);
    localparam int KW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int CW  = $clog2(COLUMN_MAX + 64'd1);
    localparam int QD  = wwkm_pkg::Q_DEPTH;
    localparam int QW  = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    // configuration
    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic [4:0]  r_kw_len;
    logic        r_exact_case;
    logic        r_whole_word;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_present;
    logic        r_in_eol;
    logic        r_in_sof;

    // line and file state
    logic [7:0]    r_recent [KEY_BYTES+1];
    logic [7:0]    n_recent [KEY_BYTES+1];
    logic [CW-1:0] r_col,   n_col;
    logic [31:0]   r_line,  n_line;
    logic [31:0]   r_total, n_total;
    logic [KW-1:0] r_blk,   n_blk;
    logic          r_pend,  n_pend;
    logic [15:0]   r_pcol,  n_pcol;
    logic          r_pleft, n_pleft;

    // result queue
    wwkm_pkg::t_result r_q [QD];
    wwkm_pkg::t_result n_q [QD];
    logic [QCW-1:0]    r_cnt, n_cnt;

    logic                 in_accept;
    logic                 go;
    logic                 pop;
    logic [LW-1:0]        len;
    logic [7:0]           key_b [KEY_BYTES];
    logic [127:0]         key_all;
    logic                 res_a;
    logic                 res_b;
    wwkm_pkg::t_result    rec_a;
    wwkm_pkg::t_result    rec_b;
    wwkm_pkg::t_result    res0;
    logic [1:0]           n_res;
    logic [QCW-1:0]       base;

    // working values of the match logic
    logic [31:0]   line0;
    logic [KW-1:0] kidx;
    logic          all_eq;
    logic          hit;
    logic          left_ok;
    logic [32:0]   start;
    logic [32:0]   col_ext;

    // Handshake
    assign go        = r_in_valid && (r_cnt <= QCW'(QD - 2));
    assign o_stall   = !i_rst_n || (r_in_valid && !go);
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = (r_cnt != '0);
    assign pop       = o_valid && !i_stall;

    assign o_line_number   = r_q[0].line_number;
    assign o_match_column  = r_q[0].match_column;
    assign o_total_matches = r_q[0].total_matches;
    assign o_last_result   = r_q[0].last_result;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_kw_len     <= 5'd1;
            r_exact_case <= 1'b0;
            r_whole_word <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wwkm_pkg::CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                wwkm_pkg::CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                wwkm_pkg::CFG_KEY_LEN:    r_kw_len     <= i_cfg_data[4:0];
                wwkm_pkg::CFG_EXACT_CASE: r_exact_case <= i_cfg_data[0];
                wwkm_pkg::CFG_WHOLE_WORD: r_whole_word <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp keyword length to the window
    always_comb begin
        if (32'(r_kw_len) > KEY_BYTES) begin
            len = LW'(KEY_BYTES);
        end else begin
            len = LW'(r_kw_len);
        end
    end

    // Unpack keyword bytes; bytes past the configured sixteen read as zero
    assign key_all = {r_key_high, r_key_low};
    always_comb begin
        for (int i = 0; i < KEY_BYTES; i++) begin
            key_b[i] = (i < 16) ? key_all[8*(i%16) +: 8] : 8'd0;
        end
    end

    // Match one request against the stored line state
    always_comb begin
        // start from stored state, restarted on a new file
        line0   = r_in_sof ? 32'd1 : r_line;
        n_total = r_in_sof ? 32'd0 : r_total;
        for (int i = 0; i <= KEY_BYTES; i++) begin
            n_recent[i] = r_in_sof ? 8'd0 : r_recent[i];
        end
        n_col   = r_in_sof ? '0 : r_col;
        n_blk   = r_in_sof ? '0 : r_blk;
        n_pend  = r_in_sof ? 1'b0 : r_pend;
        n_pcol  = r_in_sof ? 16'd0 : r_pcol;
        n_pleft = r_in_sof ? 1'b0 : r_pleft;
        n_line  = line0;
        res_a   = 1'b0;
        res_b   = 1'b0;
        rec_a   = '0;
        rec_b   = '0;
        all_eq  = 1'b1;
        hit     = 1'b0;
        left_ok = 1'b0;
        kidx    = '0;
        col_ext = 33'(n_col);
        start   = '0;

        if (r_in_present) begin
            // decide the waiting candidate with this byte as its right neighbor
            if (n_pend && (!r_whole_word ||
                           (n_pleft && !wwkm_pkg::is_word(r_in_byte)))) begin
                res_a   = 1'b1;
                n_total = wwkm_pkg::sat_inc(n_total);
            end
            rec_a.line_number   = line0;
            rec_a.match_column  = n_pcol;
            rec_a.total_matches = n_total;
            n_pend = 1'b0;

            // shift the new byte into the window
            for (int i = KEY_BYTES; i > 0; i--) begin
                n_recent[i] = n_recent[i-1];
            end
            n_recent[0] = r_in_byte;

            // compare the window against the keyword, newest byte to last key byte
            for (int j = 0; j < KEY_BYTES; j++) begin
                if (LW'(j) < len) begin
                    kidx = KW'(len - LW'(1) - LW'(j));
                    if (wwkm_pkg::fold(n_recent[j], r_exact_case) !=
                        wwkm_pkg::fold(key_b[kidx], r_exact_case)) begin
                        all_eq = 1'b0;
                    end
                end
            end
            hit = (len != '0) && (n_blk == '0) && (col_ext + 33'd1 >= 33'(len)) && all_eq;
            left_ok = (col_ext + 33'd1 == 33'(len)) || !wwkm_pkg::is_word(n_recent[len]);
            start   = col_ext + 33'd1 - 33'(len);

            // advance the column, freezing at the limit
            if (col_ext < 33'(COLUMN_MAX)) begin
                n_col = n_col + CW'(1);
            end

            // record a new candidate or count down the blocked span
            if (hit) begin
                n_pend  = 1'b1;
                n_pcol  = (start > 33'h0_FFFF) ? 16'hFFFF : start[15:0];
                n_pleft = left_ok;
                n_blk   = KW'(len - LW'(1));
            end else if (n_blk != '0) begin
                n_blk = n_blk - KW'(1);
            end
        end

        if (r_in_eol) begin
            // decide the waiting candidate at the line edge
            if (n_pend && (!r_whole_word || n_pleft)) begin
                res_b   = 1'b1;
                n_total = wwkm_pkg::sat_inc(n_total);
            end
            rec_b.line_number   = line0;
            rec_b.match_column  = n_pcol;
            rec_b.total_matches = n_total;
            rec_b.last_result   = 1'b1;
            // drop line state and move to the next line
            for (int i = 0; i <= KEY_BYTES; i++) begin
                n_recent[i] = 8'd0;
            end
            n_col   = '0;
            n_blk   = '0;
            n_pend  = 1'b0;
            n_pcol  = 16'd0;
            n_pleft = 1'b0;
            n_line  = wwkm_pkg::sat_inc(line0);
        end
        rec_a.last_result = !res_b;
    end

    // Pack results into the queue behind the entries still waiting
    always_comb begin
        n_res = {1'b0, res_a} + {1'b0, res_b};
        res0  = res_a ? rec_a : rec_b;
        base  = r_cnt - QCW'(pop);
        for (int i = 0; i < QD; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        if (go && (n_res != 2'd0)) begin
            n_q[base[QW-1:0]] = res0;
        end
        if (go && (n_res == 2'd2)) begin
            n_q[QW'(base + QCW'(1))] = rec_b;
        end
        n_cnt = base + (go ? QCW'(n_res) : QCW'(0));
    end

    // Hold the input request until the match logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte    <= i_text_byte;
            r_in_present <= i_byte_present;
            r_in_eol     <= i_end_of_line;
            r_in_sof     <= i_start_of_file;
        end
    end

    // Commit line and file state after each matched request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= KEY_BYTES; i++) begin
                r_recent[i] <= 8'd0;
            end
            r_col   <= '0;
            r_line  <= 32'd1;
            r_total <= 32'd0;
            r_blk   <= '0;
            r_pend  <= 1'b0;
            r_pcol  <= 16'd0;
            r_pleft <= 1'b0;
        end else if (go) begin
            for (int i = 0; i <= KEY_BYTES; i++) begin
                r_recent[i] <= n_recent[i];
            end
            r_col   <= n_col;
            r_line  <= n_line;
            r_total <= n_total;
            r_blk   <= n_blk;
            r_pend  <= n_pend;
            r_pcol  <= n_pcol;
            r_pleft <= n_pleft;
        end
    end

    // Advance the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wwkm_checker.sv
// Port-level checks for the whole-word keyword matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wwkm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_line_number,
    input wire logic [15:0] o_match_column,
    input wire logic [31:0] o_total_matches,
    input wire logic        o_last_result
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("report valid right after reset");

    // A stalled report stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("report dropped while stalled");

    // A stalled report keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_line_number) && $stable(o_match_column) &&
                               $stable(o_total_matches) && $stable(o_last_result))
        else $error("report payload changed while stalled");

    // Lines count from one and never wrap to zero
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != 32'd0)
        else $error("report on line zero");

    // Every report has been counted in the running total
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_total_matches != 32'd0)
        else $error("report with zero running total");

endmodule

bind whole_word_keyword_matcher wwkm_checker u_wwkm_checker (.*);

`default_nettype wire
